// ----- sv/tppcu_pkg.sv -----
package tppcu_pkg;

  localparam int unsigned DutyW  = 18;
  localparam int unsigned HalfW  = 17;
  localparam int unsigned DeadW  = 16;
  localparam int unsigned CmpW   = 32;
  localparam int unsigned NumPh  = 3;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 200;

  localparam logic [HalfW-1:0] HalfPeriodRst = 17'd60000;
  localparam logic [DeadW-1:0] DeadTimeRst   = 16'd0;

  // Configuration register indexes.
  localparam logic CfgHalfPeriod = 1'b0;
  localparam logic CfgDeadTime   = 1'b1;

  typedef enum logic [1:0] {
    PhInit    = 2'd0,
    PhLow     = 2'd1,
    PhHigh    = 2'd2,
    PhRestart = 2'd3
  } phase_e;

  // Per-tick control decision from the phase sequencer.
  typedef struct packed {
    logic upd;      // load compares from the lanes
    logic clr;      // zero all compares
    logic falling;  // falling-half formula
    logic sel;      // duty buffer the lanes use
    logic req;      // host update request
    logic trip;     // trip flag after this tick
    logic enabled;  // enabled flag after this tick
  } ctl_t;

  typedef logic [CmpW-1:0] cmp_t;

endpackage

// ----- sv/tppcu_lane.sv -----
module tppcu_lane (
  input  logic [tppcu_pkg::DutyW-1:0] duty0_i,
  input  logic [tppcu_pkg::DutyW-1:0] duty1_i,
  input  logic                        sel_i,
  input  logic                        falling_i,
  input  logic [tppcu_pkg::HalfW-1:0] half_period_i,
  input  logic [tppcu_pkg::DeadW-1:0] dead_time_i,
  output tppcu_pkg::cmp_t             cmp_high_o,
  output tppcu_pkg::cmp_t             cmp_low_o
);
  import tppcu_pkg::*;

  logic [DutyW-1:0] duty;
  logic [HalfW-1:0] half_duty;
  cmp_t             hi;

  assign duty      = sel_i ? duty1_i : duty0_i;
  assign half_duty = duty[DutyW-1:1];

  // Falling half counts down from the period midpoint; both sums wrap at 32 bits.
  always_comb begin
    if (falling_i) begin
      hi        = cmp_t'(half_period_i) - cmp_t'(half_duty);
      cmp_low_o = hi - cmp_t'(dead_time_i);
    end else begin
      hi        = cmp_t'(half_duty);
      cmp_low_o = hi + cmp_t'(dead_time_i);
    end
  end

  assign cmp_high_o = hi;

endmodule

// ----- sv/tppcu_ctrl.sv -----
module tppcu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            sel_i,
  input  logic            en_i,
  output tppcu_pkg::ctl_t ctl_o
);
  import tppcu_pkg::*;

  phase_e phase_q, phase_d;
  logic   skip_q, skip_d;
  logic   latched_q, latched_d;
  logic   enabled_q, enabled_d;
  logic   trip_q, trip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhInit;
      skip_q    <= 1'b0;
      latched_q <= 1'b0;
      enabled_q <= 1'b0;
      trip_q    <= 1'b1;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      latched_q <= latched_d;
      enabled_q <= enabled_d;
      trip_q    <= trip_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    latched_d   = latched_q;
    enabled_d   = enabled_q;
    trip_d      = trip_q;
    ctl_o.upd     = 1'b0;
    ctl_o.clr     = 1'b0;
    ctl_o.falling = 1'b0;
    ctl_o.sel     = latched_q;
    ctl_o.req     = 1'b0;
    unique case (phase_q)
      PhInit: begin
        // Every other tick is skipped while waiting for an enable.
        if (skip_q) begin
          skip_d = 1'b0;
        end else begin
          skip_d    = 1'b1;
          ctl_o.req = 1'b1;
          if (en_i) begin
            enabled_d     = 1'b1;
            trip_d        = 1'b0;
            latched_d     = sel_i;
            ctl_o.sel     = sel_i;
            ctl_o.falling = 1'b1;
            ctl_o.upd     = 1'b1;
            phase_d       = PhHigh;
          end
        end
      end
      PhLow: begin
        latched_d     = sel_i;
        ctl_o.sel     = sel_i;
        ctl_o.req     = 1'b1;
        ctl_o.falling = 1'b1;
        ctl_o.upd     = 1'b1;
        phase_d       = PhHigh;
      end
      PhHigh: begin
        ctl_o.upd = 1'b1;
        phase_d   = en_i ? PhLow : PhRestart;
      end
      PhRestart: begin
        ctl_o.clr = 1'b1;
        trip_d    = 1'b1;
        phase_d   = PhInit;
      end
      default: begin
        phase_d = PhInit;
      end
    endcase
    ctl_o.trip    = trip_d;
    ctl_o.enabled = enabled_d;
  end

endmodule

// ----- sv/three_phase_pwm_compare_update.sv -----
// Center-aligned three-phase PWM compare update with dead time. Each input word
// is one PWM reload tick carrying two buffers of U/V/W duties, a buffer select
// (tuser) and a drive enable; each accepted word yields exactly one output word
// holding the six compare values after the tick plus the trip-hold, update-request
// and outputs-enabled flags. A phase sequencer steps through init, falling half,
// rising half and restart; three identical lanes, one per motor phase, compute the
// high and low compares in parallel and the top level merges them into the held
// compare registers. The full update is combinational, so a word can be accepted
// every cycle while the skid register is free; the result is registered into the
// output stage on acceptance. A two-entry output stage (main register plus skid
// register) lets the input keep flowing for one word while the output side is
// stalled, and s_axis_tready depends only on registered state. Configuration (half
// period at index 0, dead time at index 1) is written through cfg_we_i; the user must
// write it only while no tick is in flight, as the block itself does not enforce it.
module three_phase_pwm_compare_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [tppcu_pkg::HalfW-1:0]          cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: duty_u_buf0, duty_v_buf0, duty_w_buf0, duty_u_buf1,
  // duty_v_buf1, duty_w_buf1 (18 bits each), drive_enable, zero fill.
  input  logic [tppcu_pkg::InDataW-1:0]        s_axis_tdata,
  // tuser: buffer_select.
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata from bit 0: cmp_high_u, cmp_high_v, cmp_high_w, cmp_low_u, cmp_low_v,
  // cmp_low_w (32 bits each), trip_hold, request_update, outputs_enabled, zero fill.
  output logic [tppcu_pkg::OutDataW-1:0]       m_axis_tdata
);
  import tppcu_pkg::*;

  logic [HalfW-1:0] half_period_q;
  logic [DeadW-1:0] dead_time_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
      dead_time_q   <= DeadTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPeriod: half_period_q <= cfg_wdata_i;
        CfgDeadTime:   dead_time_q   <= cfg_wdata_i[DeadW-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic skid_valid_q;
  logic out_valid_q;

  assign s_axis_tready = ~skid_valid_q;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Unpack the input word.
  logic [DutyW-1:0] duty0 [NumPh];
  logic [DutyW-1:0] duty1 [NumPh];
  logic             drive_en;

  for (genvar p = 0; p < NumPh; p++) begin : g_unpack
    assign duty0[p] = s_axis_tdata[p*DutyW +: DutyW];
    assign duty1[p] = s_axis_tdata[(p+NumPh)*DutyW +: DutyW];
  end
  assign drive_en = s_axis_tdata[2*NumPh*DutyW];

  ctl_t ctl;

  tppcu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sel_i    (s_axis_tuser),
    .en_i     (drive_en),
    .ctl_o    (ctl)
  );

  // One lane per motor phase.
  cmp_t lane_hi [NumPh];
  cmp_t lane_lo [NumPh];

  for (genvar p = 0; p < NumPh; p++) begin : g_lane
    tppcu_lane u_lane (
      .duty0_i       (duty0[p]),
      .duty1_i       (duty1[p]),
      .sel_i         (ctl.sel),
      .falling_i     (ctl.falling),
      .half_period_i (half_period_q),
      .dead_time_i   (dead_time_q),
      .cmp_high_o    (lane_hi[p]),
      .cmp_low_o     (lane_lo[p])
    );
  end

  // Merge: held compares are cleared on restart, reloaded from the lanes on an
  // update tick, and otherwise repeated.
  cmp_t cmp_hi_q [NumPh];
  cmp_t cmp_lo_q [NumPh];
  cmp_t cmp_hi_d [NumPh];
  cmp_t cmp_lo_d [NumPh];

  always_comb begin
    for (int p = 0; p < NumPh; p++) begin
      if (ctl.clr) begin
        cmp_hi_d[p] = '0;
        cmp_lo_d[p] = '0;
      end else if (ctl.upd) begin
        cmp_hi_d[p] = lane_hi[p];
        cmp_lo_d[p] = lane_lo[p];
      end else begin
        cmp_hi_d[p] = cmp_hi_q[p];
        cmp_lo_d[p] = cmp_lo_q[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPh; p++) begin
        cmp_hi_q[p] <= '0;
        cmp_lo_q[p] <= '0;
      end
    end else if (accept) begin
      for (int p = 0; p < NumPh; p++) begin
        cmp_hi_q[p] <= cmp_hi_d[p];
        cmp_lo_q[p] <= cmp_lo_d[p];
      end
    end
  end

  // Pack the result word.
  logic [OutDataW-1:0] result;

  always_comb begin
    result = '0;
    for (int p = 0; p < NumPh; p++) begin
      result[p*CmpW +: CmpW]         = cmp_hi_d[p];
      result[(p+NumPh)*CmpW +: CmpW] = cmp_lo_d[p];
    end
    result[2*NumPh*CmpW]     = ctl.trip;
    result[2*NumPh*CmpW + 1] = ctl.req;
    result[2*NumPh*CmpW + 2] = ctl.enabled;
  end

  // Two-entry output stage. New words enter only while the skid slot is free,
  // so a pop with a full skid slot never coincides with a push.
  logic [OutDataW-1:0] out_q;
  logic [OutDataW-1:0] skid_q;
  logic                pop;

  assign pop = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept && (pop || !out_valid_q)) begin
      out_q <= result;
    end
    if (accept && out_valid_q && !pop) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- sim/tb_three_phase_pwm_compare_update.sv -----
`timescale 1ns / 100ps

module tb_three_phase_pwm_compare_update;
  import tppcu_pkg::*;

  localparam int unsigned NumDirected = 20;
  localparam int unsigned NumCfgSets  = 8;
  localparam int unsigned TicksPerSet = 236;
  localparam logic [DutyW-1:0] DMax   = '1;

  // One reload tick as it travels on the slave side. The duty array packs
  // as buffer-major, phase-minor with U of buffer zero in the lowest bits,
  // which matches the tdata layout exactly.
  typedef struct packed {
    logic                             sel;
    logic                             en;
    logic [1:0][NumPh-1:0][DutyW-1:0] duty;
  } reload_tick_t;

  // One result word. Declared from the top bit down so that a cast of the
  // low 195 bits of m_axis_tdata lands every field in place.
  typedef struct packed {
    logic                       on;
    logic                       req;
    logic                       trip;
    logic [NumPh-1:0][CmpW-1:0] lo;
    logic [NumPh-1:0][CmpW-1:0] hi;
  } compare_word_t;

  // Directed stimulus row. Where fixed is set, the row's result is typed in:
  // all six compares are zero in those rows and only the flags are given.
  typedef struct packed {
    logic [DutyW-1:0] u0, v0, w0, u1, v1, w1;
    logic             sel, en;
    logic             fixed, trip, req, on;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [HalfW-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // Fields from bit 0: duty_u_buf0, duty_v_buf0, duty_w_buf0, duty_u_buf1,
  // duty_v_buf1, duty_w_buf1, drive_enable, zero fill.
  logic [InDataW-1:0]  s_axis_tdata;
  // Fields: buffer_select.
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // Fields from bit 0: cmp_high_u/v/w, cmp_low_u/v/w, trip_hold,
  // request_update, outputs_enabled, zero fill.
  logic [OutDataW-1:0] m_axis_tdata;

  three_phase_pwm_compare_update u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Shadow copy of the block's registers and phase machine.
  logic [HalfW-1:0]           half_period_q;
  logic [DeadW-1:0]           dead_time_q;
  phase_e                     pwm_phase;
  logic                       skip_pending;
  logic                       buf_latched;
  logic                       run_flag;
  logic                       trip_q;
  logic [NumPh-1:0][CmpW-1:0] cmp_hi;
  logic [NumPh-1:0][CmpW-1:0] cmp_lo;

  compare_word_t expected_updates [$];
  int            mismatches;
  int            words_seen;
  int            send_idle_pct;
  int            recv_stall_pct;

  // The directed part walks the machine through every phase. It starts with
  // a stop request in init, then an enable on the skipped init tick (which
  // must be ignored), then a full run where the high half must use the
  // buffer latched in the previous half even if the select changes. A low
  // half ignores the enable, and a high half with the enable low leads to
  // restart, which zeroes the compares while the enabled flag stays set.
  // Later rows cover buffer one, duties above twice the half period (the
  // high compare wraps), and the init skip pattern after a second restart.
  dir_row_t directed_ticks [NumDirected] = '{
    '{18'd0,   18'd0,      18'd0,      18'd0,  18'd0, 18'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{DMax,    DMax,       DMax,       DMax,   DMax,  DMax,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{18'd0,   DMax,       18'd1,      DMax,   18'd0, DMax,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{DMax,    18'd0,      18'd2,      18'd0,  DMax,  18'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'd5,   18'd6,      18'd7,      DMax,   18'd1, 18'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'd3,   DMax,       18'd0,      18'd1,  DMax,  18'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'd10,  18'd11,     18'd12,     18'd13, 18'd14, 18'd15, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{DMax,    DMax,       DMax,       18'd0,  18'd0, 18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{DMax,    DMax,       DMax,       DMax,   DMax,  DMax,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{18'd1,   18'd2,      18'd3,      18'd4,  18'd5, 18'd6, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{18'd0,   18'd0,      18'd0,      DMax,   DMax,  DMax,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{DMax,    DMax,       DMax,       DMax,   DMax,  DMax,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'h20000, 18'd120000, DMax,     18'd7,  18'd8, 18'd9, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'd0,   18'd1,      18'h2AAAA,  18'd0,  18'd0, 18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'd9,   18'd9,      18'd9,      18'd9,  18'd9, 18'd9, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{18'd4,   18'd4,      18'd4,      18'd4,  18'd4, 18'd4, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{18'd8,   18'd8,      18'd8,      18'd8,  18'd8, 18'd8, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
    '{18'd2,   18'd2,      18'd2,      18'd2,  18'd2, 18'd2, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{18'd100, 18'd200,    18'd300,    18'd400, 18'd500, 18'd600, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{18'd1000, 18'd2000,  18'd3000,   18'd4000, 18'd5000, 18'd6000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  // Register settings for the random part, extremes first.
  logic [HalfW-1:0] cfg_half [NumCfgSets];
  logic [DeadW-1:0] cfg_dead [NumCfgSets];

  // Loads the six compares from the latched buffer. The falling half counts
  // down from the half period and puts the low side dead time earlier; the
  // rising half puts it later. Everything wraps at 32 bits, no saturation.
  function automatic void load_compares(reload_tick_t t, bit falling);
    cmp_t half_duty;
    for (int ph = 0; ph < NumPh; ph++) begin
      half_duty = cmp_t'(t.duty[buf_latched][ph]) >> 1;
      if (falling) begin
        cmp_hi[ph] = cmp_t'(half_period_q) - half_duty;
        cmp_lo[ph] = cmp_hi[ph] - cmp_t'(dead_time_q);
      end else begin
        cmp_hi[ph] = half_duty;
        cmp_lo[ph] = half_duty + cmp_t'(dead_time_q);
      end
    end
  endfunction

  // Advances the shadow phase machine by one reload tick and returns the
  // word the block must produce for it.
  function automatic compare_word_t compute_compare_update(reload_tick_t t);
    compare_word_t w;
    logic          req;
    req = 1'b0;
    case (pwm_phase)
      PhInit: begin
        // Every other init tick is skipped outright.
        if (skip_pending) begin
          skip_pending = 1'b0;
        end else begin
          skip_pending = 1'b1;
          req          = 1'b1;
          if (t.en) begin
            run_flag    = 1'b1;
            trip_q      = 1'b0;
            buf_latched = t.sel;
            load_compares(t, 1'b1);
            pwm_phase   = PhHigh;
          end
        end
      end
      PhLow: begin
        buf_latched = t.sel;
        req         = 1'b1;
        load_compares(t, 1'b1);
        pwm_phase   = PhHigh;
      end
      PhHigh: begin
        load_compares(t, 1'b0);
        pwm_phase = t.en ? PhLow : PhRestart;
      end
      default: begin
        cmp_hi    = '0;
        cmp_lo    = '0;
        trip_q    = 1'b1;
        pwm_phase = PhInit;
      end
    endcase
    w.hi   = cmp_hi;
    w.lo   = cmp_lo;
    w.trip = trip_q;
    w.req  = req;
    w.on   = run_flag;
    return w;
  endfunction

  // Random duties lean on the edges: zero, all ones, values up to at most
  // twice the half period (no wrap) and fully random values (mostly wrap).
  function automatic reload_tick_t random_tick();
    reload_tick_t t;
    for (int b = 0; b < 2; b++) begin
      for (int ph = 0; ph < NumPh; ph++) begin
        case ($urandom_range(9))
          0:       t.duty[b][ph] = '0;
          1:       t.duty[b][ph] = DMax;
          2, 3, 4: t.duty[b][ph] = DutyW'($urandom_range(2 * int'(half_period_q)));
          default: t.duty[b][ph] = DutyW'($urandom);
        endcase
      end
    end
    t.sel = 1'($urandom_range(1));
    // Mostly keep the drive running so that long low/high sequences occur;
    // the occasional stop sends the machine through restart and init.
    t.en  = ($urandom_range(99) < 92);
    return t;
  endfunction

  // Drives one word at the current falling edge, with random gaps before
  // it, and waits for acceptance. The expectation is queued at the edge the
  // word is taken. Returns at a falling edge.
  task automatic send_tick(reload_tick_t t, bit fixed, compare_word_t typed);
    compare_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, t.en, t.duty};
    s_axis_tuser  <= t.sel;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = compute_compare_update(t);
    expected_updates.push_back(fixed ? typed : predicted);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every expected word has come back, then
  // lets a little margin pass.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes both registers on back-to-back cycles while the block is idle.
  task automatic configure(logic [HalfW-1:0] half, logic [DeadW-1:0] dead);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgHalfPeriod;
    cfg_wdata_i <= half;
    @(negedge clk_i);
    cfg_idx_i   <= CfgDeadTime;
    cfg_wdata_i <= HalfW'(dead);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    half_period_q = half;
    dead_time_q   = dead;
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(string what, logic [CmpW-1:0] want, logic [CmpW-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in word %0d, %s: expected %0d, got %0d", words_seen, what, want, got);
  endtask

  // The receiver decides its ready at each falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output monitor: each accepted word is checked against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    compare_word_t got;
    compare_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(compare_word_t)-1:0];
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("word %0d arrived with none expected", words_seen);
      end else begin
        want = expected_updates.pop_front();
        for (int ph = 0; ph < NumPh; ph++) begin
          if (got.hi[ph] !== want.hi[ph])
            note_mismatch($sformatf("cmp_high[%0d]", ph), want.hi[ph], got.hi[ph]);
          if (got.lo[ph] !== want.lo[ph])
            note_mismatch($sformatf("cmp_low[%0d]", ph), want.lo[ph], got.lo[ph]);
        end
        if (got.trip !== want.trip)
          note_mismatch("trip_hold", CmpW'(want.trip), CmpW'(got.trip));
        if (got.req !== want.req)
          note_mismatch("request_update", CmpW'(want.req), CmpW'(got.req));
        if (got.on !== want.on)
          note_mismatch("outputs_enabled", CmpW'(want.on), CmpW'(got.on));
      end
      words_seen++;
    end
  end

  // Upper bound on the run; a correct run finishes in a small fraction.
  initial begin
    #3_200_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    reload_tick_t  t;
    compare_word_t typed;
    dir_row_t      row;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgHalfPeriod;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    mismatches     = 0;
    words_seen     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    half_period_q = HalfPeriodRst;
    dead_time_q   = DeadTimeRst;
    pwm_phase     = PhInit;
    skip_pending  = 1'b0;
    buf_latched   = 1'b0;
    run_flag      = 1'b0;
    trip_q        = 1'b1;
    cmp_hi        = '0;
    cmp_lo        = '0;

    cfg_half = '{17'd0, 17'd131071, 17'd0, 17'd131071, 17'd0, 17'd0, 17'd60000, 17'd0};
    cfg_dead = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0};
    for (int s = 4; s < NumCfgSets; s++) begin
      if (s != 6) begin
        cfg_half[s] = HalfW'($urandom);
        cfg_dead[s] = DeadW'($urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset register values, no idling.
    for (int i = 0; i < NumDirected; i++) begin
      row = directed_ticks[i];
      t.duty[0][0] = row.u0;
      t.duty[0][1] = row.v0;
      t.duty[0][2] = row.w0;
      t.duty[1][0] = row.u1;
      t.duty[1][1] = row.v1;
      t.duty[1][2] = row.w1;
      t.sel        = row.sel;
      t.en         = row.en;
      typed        = '0;
      typed.trip   = row.trip;
      typed.req    = row.req;
      typed.on     = row.on;
      send_tick(t, row.fixed, typed);
    end

    // Random part: one register setting per set, cycling through the
    // idling patterns (none, sender gaps, receiver stalls, light both).
    for (int s = 0; s < NumCfgSets; s++) begin
      drain();
      configure(cfg_half[s], cfg_dead[s]);
      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int i = 0; i < TicksPerSet; i++) begin
        send_tick(random_tick(), 1'b0, '0);
        // Once, let the output side empty completely in mid-stream.
        if (s == 5 && i == TicksPerSet / 2) drain();
      end
    end

    drain();
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
